FILE: rtl/ucs_pkg.sv
// Shared types and constants for the URI component splitter.
// Character codes, component and status codes, and the snapshot passed from scan to emit.
// Depends on nothing.
package ucs_pkg;

	localparam int MAX_URI_LEN_DEF = 4096;
	localparam int OUT_W           = 12;
	localparam int COMP_W          = 3;
	localparam int STATUS_W        = 2;
	localparam int NCOMP           = 7;

	localparam logic [7:0] CH_NUL      = 8'h00;
	localparam logic [7:0] CH_COLON    = 8'h3A;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_QMARK    = 8'h3F;
	localparam logic [7:0] CH_HASH     = 8'h23;
	localparam logic [7:0] CH_AT       = 8'h40;
	localparam logic [7:0] CH_RBRACKET = 8'h5D;

	typedef enum logic [COMP_W-1:0] {
		COMP_SCHEME,
		COMP_USERINFO,
		COMP_HOST,
		COMP_PORT,
		COMP_PATH,
		COMP_QUERY,
		COMP_FRAGMENT
	} comp_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_NO_COLON,
		ST_TOO_LONG
	} status_t;

	typedef struct packed {
		logic                        fail;
		status_t                     status;
		logic [NCOMP-1:0]            present;
		logic [NCOMP-1:0][OUT_W-1:0] start;
		logic [NCOMP-1:0][OUT_W-1:0] stop;
	} snap_t;

endpackage

FILE: rtl/ucs_if.sv
// Valid/ready channel interfaces for the URI component splitter.
// ucs_in_if carries characters, ucs_out_if carries component results; uses ucs_pkg widths.
interface ucs_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] char_byte;

	modport source (output valid, output kind, output char_byte, input ready);
	modport sink (input valid, input kind, input char_byte, output ready);
endinterface

interface ucs_out_if;
	logic                         valid;
	logic                         ready;
	logic [ucs_pkg::COMP_W-1:0]   component;
	logic                         present;
	logic [ucs_pkg::OUT_W-1:0]    start_res;
	logic [ucs_pkg::OUT_W-1:0]    length;
	logic [ucs_pkg::STATUS_W-1:0] status;
	logic                         last;

	modport source (output valid, output component, output present, output start_res,
		output length, output status, output last, input ready);
	modport sink (input valid, input component, input present, input start_res,
		input length, input status, input last, output ready);
endinterface

FILE: rtl/ucs_scan.sv
// Input register and per-character scanner of the URI component splitter.
// Tracks delimiter positions and builds the end-of-string snapshot; uses ucs_pkg, ucs_in_if.
module ucs_scan #(
	parameter int MAX_URI_LEN = ucs_pkg::MAX_URI_LEN_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ucs_in_if.sink         in_item,
	output logic           snap_valid,
	output ucs_pkg::snap_t snap,
	input  logic           snap_ready
);
	import ucs_pkg::*;

	localparam int PW = $clog2(MAX_URI_LEN);
	localparam logic [PW-1:0] LAST_POS = PW'(MAX_URI_LEN - 1);
	localparam logic [PW-1:0] ONE      = PW'(1);

	typedef enum logic [2:0] {
		PH_SCHEME,
		PH_SLASH1,
		PH_SLASH2,
		PH_AUTH,
		PH_PATH,
		PH_QUERY,
		PH_FRAG
	} phase_t;

	function automatic logic [OUT_W-1:0] to12(input logic [PW-1:0] v);
		logic [PW+OUT_W-1:0] t;
		t = {{OUT_W{1'b0}}, v};
		return t[OUT_W-1:0];
	endfunction

	logic          v_s1;
	logic          kind_s1;
	logic [7:0]    char_s1;
	logic          end_s1;
	logic          go_s1;

	phase_t        phase_q, phase_n;
	logic [PW-1:0] pos_q, pos_n;
	logic [PW-1:0] scheme_end_q, scheme_end_n;
	logic [PW-1:0] auth_start_q, auth_start_n;
	logic [PW-1:0] auth_end_q, auth_end_n;
	logic [PW-1:0] path_start_q, path_start_n;
	logic [PW-1:0] at_q, at_n;
	logic [PW-1:0] colon_q, colon_n;
	logic [PW-1:0] br_q, br_n;
	logic [PW-1:0] qs_q, qs_n;
	logic [PW-1:0] fs_q, fs_n;
	logic          at_seen_q, at_seen_n;
	logic          colon_seen_q, colon_seen_n;
	logic          br_seen_q, br_seen_n;
	logic          q_seen_q, q_seen_n;
	logic          f_seen_q, f_seen_n;
	logic          auth_seen_q, auth_seen_n;
	logic          too_long_q, too_long_n;

	logic [PW-1:0] path_start_f;
	logic [PW-1:0] auth_end_f;
	logic [PW-1:0] host_s;
	logic [PW-1:0] host_e;
	logic [PW-1:0] q_e;
	logic [PW-1:0] path_e;
	logic          port;

	assign end_s1        = kind_s1 || (char_s1 == CH_NUL);
	assign go_s1         = v_s1 && (!end_s1 || snap_ready);
	assign in_item.ready = !v_s1 || go_s1;
	assign snap_valid    = v_s1 && end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_item.ready) begin
			v_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.ready && in_item.valid) begin
			kind_s1 <= in_item.kind;
			char_s1 <= in_item.char_byte;
		end
	end

	always_comb begin
		phase_n      = phase_q;
		pos_n        = pos_q;
		scheme_end_n = scheme_end_q;
		auth_start_n = auth_start_q;
		auth_end_n   = auth_end_q;
		path_start_n = path_start_q;
		at_n         = at_q;
		colon_n      = colon_q;
		br_n         = br_q;
		qs_n         = qs_q;
		fs_n         = fs_q;
		at_seen_n    = at_seen_q;
		colon_seen_n = colon_seen_q;
		br_seen_n    = br_seen_q;
		q_seen_n     = q_seen_q;
		f_seen_n     = f_seen_q;
		auth_seen_n  = auth_seen_q;
		too_long_n   = too_long_q;
		if (go_s1) begin
			if (end_s1) begin
				phase_n      = PH_SCHEME;
				pos_n        = '0;
				scheme_end_n = '0;
				auth_start_n = '0;
				auth_end_n   = '0;
				path_start_n = '0;
				at_n         = '0;
				colon_n      = '0;
				br_n         = '0;
				qs_n         = '0;
				fs_n         = '0;
				at_seen_n    = 1'b0;
				colon_seen_n = 1'b0;
				br_seen_n    = 1'b0;
				q_seen_n     = 1'b0;
				f_seen_n     = 1'b0;
				auth_seen_n  = 1'b0;
				too_long_n   = 1'b0;
			end else if (too_long_q || pos_q >= LAST_POS) begin
				too_long_n = 1'b1;
			end else begin
				pos_n = pos_q + ONE;
				case (phase_q)
					PH_SCHEME: begin
						if (char_s1 == CH_COLON) begin
							scheme_end_n = pos_q;
							phase_n      = PH_SLASH1;
						end
					end
					PH_SLASH1: begin
						if (char_s1 == CH_SLASH) begin
							phase_n = PH_SLASH2;
						end else begin
							path_start_n = pos_q;
							phase_n      = PH_PATH;
						end
					end
					PH_SLASH2: begin
						if (char_s1 == CH_SLASH) begin
							auth_start_n = pos_q + ONE;
							auth_seen_n  = 1'b1;
							phase_n      = PH_AUTH;
						end else begin
							path_start_n = pos_q - ONE;
							phase_n      = PH_PATH;
						end
					end
					PH_AUTH: begin
						if (char_s1 == CH_SLASH || char_s1 == CH_QMARK ||
								char_s1 == CH_HASH) begin
							auth_end_n   = pos_q;
							path_start_n = pos_q;
							phase_n      = PH_PATH;
						end else if (char_s1 == CH_AT) begin
							at_n      = pos_q;
							at_seen_n = 1'b1;
						end else if (char_s1 == CH_COLON) begin
							colon_n      = pos_q;
							colon_seen_n = 1'b1;
						end else if (char_s1 == CH_RBRACKET) begin
							br_n      = pos_q;
							br_seen_n = 1'b1;
						end
					end
					default: begin
					end
				endcase
				if (phase_n == PH_PATH && char_s1 == CH_QMARK) begin
					qs_n     = pos_q + ONE;
					q_seen_n = 1'b1;
					phase_n  = PH_QUERY;
				end else if ((phase_n == PH_PATH || phase_n == PH_QUERY) &&
						char_s1 == CH_HASH) begin
					fs_n     = pos_q + ONE;
					f_seen_n = 1'b1;
					phase_n  = PH_FRAG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SCHEME;
			pos_q        <= '0;
			scheme_end_q <= '0;
			auth_start_q <= '0;
			auth_end_q   <= '0;
			path_start_q <= '0;
			at_q         <= '0;
			colon_q      <= '0;
			br_q         <= '0;
			qs_q         <= '0;
			fs_q         <= '0;
			at_seen_q    <= 1'b0;
			colon_seen_q <= 1'b0;
			br_seen_q    <= 1'b0;
			q_seen_q     <= 1'b0;
			f_seen_q     <= 1'b0;
			auth_seen_q  <= 1'b0;
			too_long_q   <= 1'b0;
		end else begin
			phase_q      <= phase_n;
			pos_q        <= pos_n;
			scheme_end_q <= scheme_end_n;
			auth_start_q <= auth_start_n;
			auth_end_q   <= auth_end_n;
			path_start_q <= path_start_n;
			at_q         <= at_n;
			colon_q      <= colon_n;
			br_q         <= br_n;
			qs_q         <= qs_n;
			fs_q         <= fs_n;
			at_seen_q    <= at_seen_n;
			colon_seen_q <= colon_seen_n;
			br_seen_q    <= br_seen_n;
			q_seen_q     <= q_seen_n;
			f_seen_q     <= f_seen_n;
			auth_seen_q  <= auth_seen_n;
			too_long_q   <= too_long_n;
		end
	end

	always_comb begin
		case (phase_q)
			PH_SLASH1: path_start_f = pos_q;
			PH_SLASH2: path_start_f = pos_q - ONE;
			PH_AUTH:   path_start_f = pos_q;
			default:   path_start_f = path_start_q;
		endcase
		auth_end_f = (phase_q == PH_AUTH) ? pos_q : auth_end_q;
		host_s     = at_seen_q ? at_q + ONE : auth_start_q;
		port       = colon_seen_q && (!at_seen_q || colon_q > at_q) &&
			(!br_seen_q || colon_q > br_q);
		host_e     = port ? colon_q : auth_end_f;
		q_e        = f_seen_q ? fs_q - ONE : pos_q;
		path_e     = q_seen_q ? qs_q - ONE : q_e;

		snap.fail    = too_long_q || (phase_q == PH_SCHEME);
		snap.status  = too_long_q ? ST_TOO_LONG : ST_NO_COLON;
		snap.present = '0;
		snap.start   = '0;
		snap.stop    = '0;

		snap.present[COMP_SCHEME] = 1'b1;
		snap.stop[COMP_SCHEME]    = to12(scheme_end_q);
		if (auth_seen_q && at_seen_q) begin
			snap.present[COMP_USERINFO] = 1'b1;
			snap.start[COMP_USERINFO]   = to12(auth_start_q);
			snap.stop[COMP_USERINFO]    = to12(at_q);
		end
		if (auth_seen_q) begin
			snap.present[COMP_HOST] = 1'b1;
			snap.start[COMP_HOST]   = to12(host_s);
			snap.stop[COMP_HOST]    = to12(host_e);
		end
		if (auth_seen_q && port) begin
			snap.present[COMP_PORT] = 1'b1;
			snap.start[COMP_PORT]   = to12(colon_q + ONE);
			snap.stop[COMP_PORT]    = to12(auth_end_f);
		end
		snap.present[COMP_PATH] = 1'b1;
		snap.start[COMP_PATH]   = to12(path_start_f);
		snap.stop[COMP_PATH]    = to12(path_e);
		if (q_seen_q) begin
			snap.present[COMP_QUERY] = 1'b1;
			snap.start[COMP_QUERY]   = to12(qs_q);
			snap.stop[COMP_QUERY]    = to12(q_e);
		end
		if (f_seen_q) begin
			snap.present[COMP_FRAGMENT] = 1'b1;
			snap.start[COMP_FRAGMENT]   = to12(fs_q);
			snap.stop[COMP_FRAGMENT]    = to12(pos_q);
		end
	end

endmodule

FILE: rtl/ucs_emit.sv
// Result sequencer of the URI component splitter.
// Holds one snapshot and sends its results through an output register; uses ucs_pkg, ucs_out_if.
module ucs_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           snap_valid,
	input  ucs_pkg::snap_t snap,
	output logic           snap_ready,
	ucs_out_if.source      out_item
);
	import ucs_pkg::*;

	snap_t             snap_q;
	logic              busy_q;
	logic [COMP_W-1:0] idx_q;
	logic              load;
	logic              last_now;

	logic              valid_q;
	logic [COMP_W-1:0] component_q;
	logic              present_q;
	logic [OUT_W-1:0]  start_q;
	logic [OUT_W-1:0]  length_q;
	logic [STATUS_W-1:0] status_q;
	logic              last_q;

	assign load       = busy_q && (!valid_q || out_item.ready);
	assign last_now   = snap_q.fail || (idx_q == COMP_FRAGMENT);
	assign snap_ready = !busy_q || (load && last_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (snap_valid && snap_ready) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (load && last_now) begin
				busy_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + COMP_W'(1);
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_item.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (snap_valid && snap_ready) begin
			snap_q <= snap;
		end
		if (load) begin
			if (snap_q.fail) begin
				component_q <= COMP_SCHEME;
				present_q   <= 1'b0;
				start_q     <= '0;
				length_q    <= '0;
				status_q    <= snap_q.status;
				last_q      <= 1'b1;
			end else begin
				component_q <= idx_q;
				present_q   <= snap_q.present[idx_q];
				start_q     <= snap_q.start[idx_q];
				length_q    <= snap_q.stop[idx_q] - snap_q.start[idx_q];
				status_q    <= ST_OK;
				last_q      <= (idx_q == COMP_FRAGMENT);
			end
		end
	end

	assign out_item.valid     = valid_q;
	assign out_item.component = component_q;
	assign out_item.present   = present_q;
	assign out_item.start_res = start_q;
	assign out_item.length    = length_q;
	assign out_item.status    = status_q;
	assign out_item.last      = last_q;

endmodule

FILE: rtl/uri_component_splitter_core.sv
// Top level of the URI component splitter: scanner followed by result sequencer.
// Depends on ucs_pkg, ucs_if, ucs_scan and ucs_emit.
//
// in_item takes one transaction per character (kind 0) and one to close the string
// (kind 1, or a zero character). Characters are taken at one per clock, back to back.
// out_item gives seven component transactions per string (scheme, userinfo, host,
// port, path, query, fragment, last set on the fragment), or a single failure
// transaction with status no-colon or too-long and last set.
// The end-of-string passes the input and snapshot registers before the first result
// reaches the output register; the rest follow one per cycle if the receiver is ready.
// Characters of the next string are taken while the previous results drain; the
// scanner holds only a second end-of-string until the sequencer has taken the last
// result of the first.
// A stalled receiver holds the output register; the sequencer and then the input
// stop in turn. Reset clears control state, not data registers; nothing is pending.
module uri_component_splitter_core #(
	parameter int MAX_URI_LEN = ucs_pkg::MAX_URI_LEN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ucs_in_if.sink    in_item,
	ucs_out_if.source out_item
);
	import ucs_pkg::*;

	logic  snap_valid;
	logic  snap_ready;
	snap_t snap;

	ucs_scan #(
		.MAX_URI_LEN(MAX_URI_LEN)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_item    (in_item),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready)
	);

	ucs_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.snap_valid (snap_valid),
		.snap       (snap),
		.snap_ready (snap_ready),
		.out_item   (out_item)
	);

endmodule
